// ===== design/sqv_pkg.sv =====
// Shared constants, types and tables for the sphere quad vertex generator.
`timescale 1ns / 1ps
package sqv_pkg;

	localparam int CNT_W       = 9;
	localparam int IDX_W       = 8;
	localparam int RADIUS_W    = 16;
	localparam int Q14_W       = 16;
	localparam int POS_W       = 17;
	localparam int TEX_W       = 17;
	localparam int PHASE_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int BEAT_W      = 3;

	// long division: numerator k*2^33 + n needs 42 bits, divisor 2n needs 10
	localparam int DIV_NUM_W   = 42;
	localparam int DIV_DEN_W   = 10;
	localparam int DIV_REM_W   = 10;

	localparam int CORDIC_W          = 33;
	localparam int CORDIC_TABLE_LEN  = 24;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;

	localparam int MAX_DIVISIONS = 256;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 16'd256;
	localparam logic [CNT_W-1:0]    SLICE_RST  = 9'd16;
	localparam logic [CNT_W-1:0]    STACK_RST  = 9'd16;

	localparam logic [BEAT_W-1:0] LAST_BEAT = 3'd5;
	localparam logic [TEX_W-1:0]  TEX_ONE   = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS      = 2'd0,
		REG_SLICE_COUNT = 2'd1,
		REG_STACK_COUNT = 2'd2
	} cfg_reg_t;

	typedef logic signed [Q14_W-1:0] q14_t;

	// atan(2^-i) as a fraction of one turn, 2^32 per turn
	function automatic logic [PHASE_W-1:0] atan_turn(input int idx);
		logic [PHASE_W-1:0] v;
		case (idx)
			0:       v = 32'h20000000;
			1:       v = 32'h12E4051E;
			2:       v = 32'h09FB385B;
			3:       v = 32'h051111D4;
			4:       v = 32'h028B0D43;
			5:       v = 32'h0145D7E1;
			6:       v = 32'h00A2F61E;
			7:       v = 32'h00517C55;
			8:       v = 32'h0028BE53;
			9:       v = 32'h00145F2F;
			10:      v = 32'h000A2F98;
			11:      v = 32'h000517CC;
			12:      v = 32'h00028BE6;
			13:      v = 32'h000145F3;
			14:      v = 32'h0000A2FA;
			15:      v = 32'h0000517D;
			16:      v = 32'h000028BE;
			17:      v = 32'h0000145F;
			18:      v = 32'h00000A30;
			19:      v = 32'h00000518;
			20:      v = 32'h0000028C;
			21:      v = 32'h00000146;
			22:      v = 32'h000000A3;
			23:      v = 32'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// corner visited on each beat of a quad: 0,1,2,2,1,3
	function automatic logic [1:0] corner_of_beat(input logic [BEAT_W-1:0] beat);
		logic [1:0] c;
		case (beat)
			3'd0:    c = 2'd0;
			3'd1:    c = 2'd1;
			3'd2:    c = 2'd2;
			3'd3:    c = 2'd2;
			3'd4:    c = 2'd1;
			3'd5:    c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

	function automatic q14_t clamp_q14(input logic signed [33:0] v);
		q14_t r;
		if (v > 34'sd16384) begin
			r = 16'sd16384;
		end else if (v < -34'sd16384) begin
			r = -16'sd16384;
		end else begin
			r = Q14_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== design/sqv_div_cell.sv =====
// One restoring long-division cell: retires one quotient bit per cycle while en is high.
`timescale 1ns / 1ps
module sqv_div_cell (
	input  logic                            clk,
	input  logic                            en,
	input  logic [sqv_pkg::DIV_REM_W-1:0]   rem_i,
	input  logic [sqv_pkg::DIV_NUM_W-1:0]   num_i,
	input  logic [sqv_pkg::DIV_NUM_W-1:0]   quo_i,
	input  logic [sqv_pkg::DIV_DEN_W-1:0]   den_i,
	output logic [sqv_pkg::DIV_REM_W-1:0]   rem_o,
	output logic [sqv_pkg::DIV_NUM_W-1:0]   num_o,
	output logic [sqv_pkg::DIV_NUM_W-1:0]   quo_o,
	output logic [sqv_pkg::DIV_DEN_W-1:0]   den_o
);
	import sqv_pkg::*;

	logic [DIV_REM_W:0] trial;
	logic               fits;

	assign trial = {rem_i, num_i[DIV_NUM_W-1]};
	assign fits  = trial >= {1'b0, den_i};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= fits ? DIV_REM_W'(trial - {1'b0, den_i}) : DIV_REM_W'(trial);
			num_o <= {num_i[DIV_NUM_W-2:0], 1'b0};
			quo_o <= {quo_i[DIV_NUM_W-2:0], fits};
			den_o <= den_i;
		end
	end

endmodule

// ===== design/sqv_divider.sv =====
// Pipelined divider built as a row of long-division cells.
`timescale 1ns / 1ps
module sqv_divider (
	input  logic                            clk,
	input  logic                            en,
	input  logic [sqv_pkg::DIV_NUM_W-1:0]   num,
	input  logic [sqv_pkg::DIV_DEN_W-1:0]   den,
	output logic [sqv_pkg::DIV_NUM_W-1:0]   quo
);
	import sqv_pkg::*;

	logic [DIV_REM_W-1:0] rem_c [0:DIV_NUM_W];
	logic [DIV_NUM_W-1:0] num_c [0:DIV_NUM_W];
	logic [DIV_NUM_W-1:0] quo_c [0:DIV_NUM_W];
	logic [DIV_DEN_W-1:0] den_c [0:DIV_NUM_W];

	assign rem_c[0] = '0;
	assign num_c[0] = num;
	assign quo_c[0] = '0;
	assign den_c[0] = den;

	for (genvar i = 0; i < DIV_NUM_W; i++) begin : g_cell
		sqv_div_cell u_cell (
			.clk   (clk),
			.en    (en),
			.rem_i (rem_c[i]),
			.num_i (num_c[i]),
			.quo_i (quo_c[i]),
			.den_i (den_c[i]),
			.rem_o (rem_c[i+1]),
			.num_o (num_c[i+1]),
			.quo_o (quo_c[i+1]),
			.den_o (den_c[i+1])
		);
	end

	assign quo = quo_c[DIV_NUM_W];

endmodule

// ===== design/sqv_cordic_cell.sv =====
// One rotation-mode CORDIC micro-rotation, registered.
`timescale 1ns / 1ps
module sqv_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                                 clk,
	input  logic                                 en,
	input  logic signed [sqv_pkg::CORDIC_W-1:0]  x_i,
	input  logic signed [sqv_pkg::CORDIC_W-1:0]  y_i,
	input  logic signed [sqv_pkg::CORDIC_W-1:0]  z_i,
	input  logic                                 flip_i,
	output logic signed [sqv_pkg::CORDIC_W-1:0]  x_o,
	output logic signed [sqv_pkg::CORDIC_W-1:0]  y_o,
	output logic signed [sqv_pkg::CORDIC_W-1:0]  z_o,
	output logic                                 flip_o
);
	import sqv_pkg::*;

	logic signed [CORDIC_W-1:0] step;

	assign step = $signed({1'b0, atan_turn(IDX)});

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_i >= 0) begin
				x_o <= x_i - (y_i >>> IDX);
				y_o <= y_i + (x_i >>> IDX);
				z_o <= z_i - step;
			end else begin
				x_o <= x_i + (y_i >>> IDX);
				y_o <= y_i - (x_i >>> IDX);
				z_o <= z_i + step;
			end
			flip_o <= flip_i;
		end
	end

endmodule

// ===== design/sqv_cordic.sv =====
// Sine and cosine of a 32-bit phase: fold, a row of CORDIC cells, round to Q1.14.
`timescale 1ns / 1ps
module sqv_cordic #(
	parameter int STAGES = sqv_pkg::CORDIC_STAGES_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [sqv_pkg::PHASE_W-1:0]    phase,
	output sqv_pkg::q14_t                  sin_o,
	output sqv_pkg::q14_t                  cos_o
);
	import sqv_pkg::*;

	logic signed [CORDIC_W-1:0] x_c [0:STAGES];
	logic signed [CORDIC_W-1:0] y_c [0:STAGES];
	logic signed [CORDIC_W-1:0] z_c [0:STAGES];
	logic                       flip_c [0:STAGES];

	logic signed [CORDIC_W-1:0] z_in;
	logic signed [CORDIC_W-1:0] z_fold;
	logic                       flip_fold;
	logic signed [33:0]         x_rnd;
	logic signed [33:0]         y_rnd;
	q14_t                       x_cl;
	q14_t                       y_cl;

	// fold the phase into [-90, 90] degrees; a fold negates both results
	always_comb begin
		z_in      = CORDIC_W'($signed(phase));
		z_fold    = z_in;
		flip_fold = 1'b0;
		if (z_in > 33'sh040000000) begin
			z_fold    = z_in - 33'sh080000000;
			flip_fold = 1'b1;
		end else if (z_in < -33'sh040000000) begin
			z_fold    = z_in + 33'sh080000000;
			flip_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_c[0]    <= CORDIC_GAIN;
			y_c[0]    <= '0;
			z_c[0]    <= z_fold;
			flip_c[0] <= flip_fold;
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		sqv_cordic_cell #(.IDX(i)) u_cell (
			.clk    (clk),
			.en     (en),
			.x_i    (x_c[i]),
			.y_i    (y_c[i]),
			.z_i    (z_c[i]),
			.flip_i (flip_c[i]),
			.x_o    (x_c[i+1]),
			.y_o    (y_c[i+1]),
			.z_o    (z_c[i+1]),
			.flip_o (flip_c[i+1])
		);
	end

	assign x_rnd = (34'(x_c[STAGES]) + 34'sd32768) >>> 16;
	assign y_rnd = (34'(y_c[STAGES]) + 34'sd32768) >>> 16;
	assign x_cl  = clamp_q14(x_rnd);
	assign y_cl  = clamp_q14(y_rnd);

	always_ff @(posedge clk) begin
		if (en) begin
			sin_o <= flip_c[STAGES] ? -y_cl : y_cl;
			cos_o <= flip_c[STAGES] ? -x_cl : x_cl;
		end
	end

endmodule

// ===== design/sphere_quad_vertex_generator.sv =====
// Top level: UV-sphere quad request in, six triangle vertices out.
// Throughput: one vertex beat per cycle while the output is not stalled; the front end
//   expands each quad into six beats and the pipeline behind it takes a beat a cycle.
// Path from quad accept to its first vertex beat: 42 long-division cells, CORDIC fold,
//   CORDIC_STAGES cells, rounding, two multiplies.
// Reset (arst_n low): clears valids and the beat sequencer; radius = 1.0, 16 slices, 16 stacks.
`timescale 1ns / 1ps
module sphere_quad_vertex_generator #(
	parameter int CORDIC_STAGES = sqv_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sqv_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sqv_pkg::CFG_DATA_W-1:0]      cfg_data,
	// quad request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [sqv_pkg::IDX_W-1:0]           stack_index,
	input  logic [sqv_pkg::IDX_W-1:0]           slice_index,
	// vertex channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [sqv_pkg::POS_W-1:0]    pos_x,
	output logic signed [sqv_pkg::POS_W-1:0]    pos_y,
	output logic signed [sqv_pkg::POS_W-1:0]    pos_z,
	output sqv_pkg::q14_t                       norm_x,
	output sqv_pkg::q14_t                       norm_y,
	output sqv_pkg::q14_t                       norm_z,
	output logic [sqv_pkg::TEX_W-1:0]           tex_u,
	output logic [sqv_pkg::TEX_W-1:0]           tex_v,
	output logic                                last_corner
);
	import sqv_pkg::*;

	localparam int CORDIC_LAT = CORDIC_STAGES + 2;

	typedef struct packed {
		logic valid;
		logic last;
		logic th_zero;
	} div_ctl_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
	} cor_ctl_t;

	// ---------------------------------------------------------------------
	// Helpers
	// ---------------------------------------------------------------------

	// zero counts act as one, counts above the limit act as the limit
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (32'(c) > MAX_DIVISIONS) begin
			r = CNT_W'(MAX_DIVISIONS);
		end else begin
			r = c;
		end
		return r;
	endfunction

	function automatic logic [TEX_W-1:0] sat_tex(input logic [DIV_NUM_W-1:0] q);
		return (q > DIV_NUM_W'(TEX_ONE)) ? TEX_ONE : q[TEX_W-1:0];
	endfunction

	// Q1.14 times Q1.14, rounded half up, optionally negated before rounding
	function automatic q14_t mul_q14(input q14_t a, input q14_t b, input logic neg);
		logic signed [33:0] p;
		p = 34'(a) * 34'(b);
		if (neg) begin
			p = -p;
		end
		return clamp_q14((p + 34'sd8192) >>> 14);
	endfunction

	// Q1.14 normal times Q8.8 radius, rounded half up to Q8.8
	function automatic logic signed [POS_W-1:0] scale_pos(input q14_t n,
			input logic [RADIUS_W-1:0] rad);
		logic signed [33:0] p;
		p = 34'(n) * $signed({18'b0, rad});
		return POS_W'((p + 34'sd8192) >>> 14);
	endfunction

	// ---------------------------------------------------------------------
	// Configuration registers; always ready, writes take effect on the next cycle
	// ---------------------------------------------------------------------
	logic [RADIUS_W-1:0] radius_q;
	logic [CNT_W-1:0]    slice_count_q;
	logic [CNT_W-1:0]    stack_count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q      <= RADIUS_RST;
			slice_count_q <= SLICE_RST;
			stack_count_q <= STACK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS:      radius_q      <= cfg_data[RADIUS_W-1:0];
				REG_SLICE_COUNT: slice_count_q <= cfg_data[CNT_W-1:0];
				REG_STACK_COUNT: stack_count_q <= cfg_data[CNT_W-1:0];
				default:         ; // unused index: drop the write
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Pipeline advance: everything moves unless the output beat is held
	// ---------------------------------------------------------------------
	logic adv;
	assign adv = !(out_valid && out_stall);

	// ---------------------------------------------------------------------
	// Front end: hold the quad and walk its six beats.  The next quad is
	// taken on the cycle the sixth beat leaves, so quads follow back to back.
	// ---------------------------------------------------------------------
	logic              busy_q;
	logic [BEAT_W-1:0] beat_q;
	logic [IDX_W-1:0]  stk_q;
	logic [IDX_W-1:0]  slc_q;
	logic              accept;

	assign in_stall = !adv || (busy_q && beat_q != LAST_BEAT);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			beat_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			beat_q <= '0;
		end else if (adv && busy_q) begin
			if (beat_q == LAST_BEAT) begin
				busy_q <= 1'b0;
				beat_q <= '0;
			end else begin
				beat_q <= beat_q + BEAT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stk_q <= stack_index;
			slc_q <= slice_index;
		end
	end

	// ---------------------------------------------------------------------
	// Beat setup: pick the corner and build the four division operands.
	// Corner bit 0 selects the lower stack, bit 1 the next slice.
	// ---------------------------------------------------------------------
	logic [1:0]           corner;
	logic [CNT_W-1:0]     ns;
	logic [CNT_W-1:0]     nl;
	logic [CNT_W-1:0]     ks;
	logic [CNT_W-1:0]     kl;

	assign corner = corner_of_beat(beat_q);
	assign ns     = eff_count(stack_count_q);
	assign nl     = eff_count(slice_count_q);
	assign ks     = CNT_W'(stk_q) + CNT_W'(corner[0]);
	assign kl     = CNT_W'(slc_q) + CNT_W'(corner[1]);

	div_ctl_t             ctl_s0;
	logic [DIV_NUM_W-1:0] num_rho_s0;
	logic [DIV_NUM_W-1:0] num_th_s0;
	logic [DIV_NUM_W-1:0] num_u_s0;
	logic [DIV_NUM_W-1:0] num_v_s0;
	logic [DIV_DEN_W-1:0] den_stk_s0;
	logic [DIV_DEN_W-1:0] den_slc_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else if (adv) begin
			ctl_s0.valid   <= busy_q;
			ctl_s0.last    <= beat_q == LAST_BEAT;
			// the wrapped slice lands back on angle zero
			ctl_s0.th_zero <= corner[1] && (kl == nl);
		end
	end

	// phase = round(k * 2^31 / stacks) and round(k * 2^32 / slices);
	// texture = round(k * 2^16 / n); all as floor((k * 2^s + n) / 2n)
	always_ff @(posedge clk) begin
		if (adv) begin
			num_rho_s0 <= (DIV_NUM_W'(ks) << 32) + DIV_NUM_W'(ns);
			num_th_s0  <= (DIV_NUM_W'(kl) << 33) + DIV_NUM_W'(nl);
			num_u_s0   <= (DIV_NUM_W'(kl) << 17) + DIV_NUM_W'(nl);
			num_v_s0   <= (DIV_NUM_W'(ks) << 17) + DIV_NUM_W'(ns);
			den_stk_s0 <= {ns, 1'b0};
			den_slc_s0 <= {nl, 1'b0};
		end
	end

	// ---------------------------------------------------------------------
	// Four division lanes, one quotient bit per cell
	// ---------------------------------------------------------------------
	logic [DIV_NUM_W-1:0] quo_rho;
	logic [DIV_NUM_W-1:0] quo_th;
	logic [DIV_NUM_W-1:0] quo_u;
	logic [DIV_NUM_W-1:0] quo_v;

	sqv_divider u_div_rho (.clk(clk), .en(adv), .num(num_rho_s0), .den(den_stk_s0),
		.quo(quo_rho));
	sqv_divider u_div_th  (.clk(clk), .en(adv), .num(num_th_s0),  .den(den_slc_s0),
		.quo(quo_th));
	sqv_divider u_div_u   (.clk(clk), .en(adv), .num(num_u_s0),   .den(den_slc_s0),
		.quo(quo_u));
	sqv_divider u_div_v   (.clk(clk), .en(adv), .num(num_v_s0),   .den(den_stk_s0),
		.quo(quo_v));

	// control rides alongside the division cells
	div_ctl_t ctl_div_q [0:DIV_NUM_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_NUM_W; i++) begin
				ctl_div_q[i] <= '0;
			end
		end else if (adv) begin
			ctl_div_q[0] <= ctl_s0;
			for (int i = 1; i < DIV_NUM_W; i++) begin
				ctl_div_q[i] <= ctl_div_q[i-1];
			end
		end
	end

	// phases wrap modulo one turn; texture values saturate
	logic [PHASE_W-1:0] phase_rho;
	logic [PHASE_W-1:0] phase_th;
	div_ctl_t           ctl_div_out;

	assign ctl_div_out = ctl_div_q[DIV_NUM_W-1];
	assign phase_rho   = quo_rho[PHASE_W-1:0];
	assign phase_th    = ctl_div_out.th_zero ? '0 : quo_th[PHASE_W-1:0];

	// ---------------------------------------------------------------------
	// Two CORDIC lanes: stack angle and slice angle of this beat's corner
	// ---------------------------------------------------------------------
	q14_t s_rho;
	q14_t c_rho;
	q14_t s_th;
	q14_t c_th;

	sqv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_rho (
		.clk(clk), .en(adv), .phase(phase_rho), .sin_o(s_rho), .cos_o(c_rho));
	sqv_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
		.clk(clk), .en(adv), .phase(phase_th), .sin_o(s_th), .cos_o(c_th));

	cor_ctl_t ctl_cor_q [0:CORDIC_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORDIC_LAT; i++) begin
				ctl_cor_q[i] <= '0;
			end
		end else if (adv) begin
			ctl_cor_q[0].valid <= ctl_div_out.valid;
			ctl_cor_q[0].last  <= ctl_div_out.last;
			ctl_cor_q[0].tex_u <= sat_tex(quo_u);
			ctl_cor_q[0].tex_v <= TEX_ONE - sat_tex(quo_v);
			for (int i = 1; i < CORDIC_LAT; i++) begin
				ctl_cor_q[i] <= ctl_cor_q[i-1];
			end
		end
	end

	cor_ctl_t ctl_cor_out;
	assign ctl_cor_out = ctl_cor_q[CORDIC_LAT-1];

	// ---------------------------------------------------------------------
	// Normal: nx = -sin(theta)*sin(rho), ny = cos(theta)*sin(rho), nz = cos(rho)
	// ---------------------------------------------------------------------
	cor_ctl_t ctl_s1;
	q14_t     nx_s1;
	q14_t     ny_s1;
	q14_t     nz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_cor_out;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1 <= mul_q14(s_th, s_rho, 1'b1);
			ny_s1 <= mul_q14(c_th, s_rho, 1'b0);
			nz_s1 <= c_rho;
		end
	end

	// ---------------------------------------------------------------------
	// Position: normal scaled by the radius
	// ---------------------------------------------------------------------
	cor_ctl_t                 ctl_s2;
	q14_t                     nx_s2;
	q14_t                     ny_s2;
	q14_t                     nz_s2;
	logic signed [POS_W-1:0]  px_s2;
	logic signed [POS_W-1:0]  py_s2;
	logic signed [POS_W-1:0]  pz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			nz_s2 <= nz_s1;
			px_s2 <= scale_pos(nx_s1, radius_q);
			py_s2 <= scale_pos(ny_s1, radius_q);
			pz_s2 <= scale_pos(nz_s1, radius_q);
		end
	end

	// ---------------------------------------------------------------------
	// Output register: hold the beat while stalled
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x       <= px_s2;
			pos_y       <= py_s2;
			pos_z       <= pz_s2;
			norm_x      <= nx_s2;
			norm_y      <= ny_s2;
			norm_z      <= nz_s2;
			tex_u       <= ctl_s2.tex_u;
			tex_v       <= ctl_s2.tex_v;
			last_corner <= ctl_s2.last;
		end
	end

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	// count delivered beats within a quad
	logic [BEAT_W-1:0] out_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
		end else if (out_valid && !out_stall) begin
			out_cnt_q <= (out_cnt_q == LAST_BEAT) ? '0 : out_cnt_q + BEAT_W'(1);
		end
	end

	a_accept_on_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!busy_q || beat_q == LAST_BEAT))
		else $error("quad accepted while beats of the previous quad remain");

	a_accept_starts_beat0: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy_q && beat_q == '0))
		else $error("accepted quad did not start at its first beat");

	a_last_on_sixth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_corner == (out_cnt_q == LAST_BEAT)))
		else $error("last_corner out of step with the vertex count");

	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tex_u <= TEX_ONE && tex_v <= TEX_ONE))
		else $error("texture coordinate above one");

endmodule

// ===== tb/sv/tb_sphere_quad_vertex_generator.sv =====
// Self-checking testbench for the sphere quad vertex generator.
`timescale 1ns / 1ps
module tb_sphere_quad_vertex_generator;
	import sqv_pkg::*;

	// Index with no register behind it; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int CLK_HALF = 6;
	localparam int DRAIN_CYCLES = 120;

	typedef enum logic {ROW_CFG, ROW_QUAD} row_kind_t;

	// One vertex beat as seen on the output channel.
	typedef struct packed {
		logic signed [POS_W-1:0] px, py, pz;
		logic signed [Q14_W-1:0] nx, ny, nz;
		logic [TEX_W-1:0]        u, v;
		logic                    last;
	} vertex_t;

	// Directed row: a register write, or a quad with optional typed-in texture
	// coordinates of its first vertex.
	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  reg_val;
		logic [IDX_W-1:0]       stk, slc;
		bit                     tex_known;
		logic [TEX_W-1:0]       u0, v0;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [IDX_W-1:0] stack_index = '0;
	logic [IDX_W-1:0] slice_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	q14_t norm_x, norm_y, norm_z;
	logic [TEX_W-1:0] tex_u, tex_v;
	logic last_corner;

	// Mirror of the block's registers.
	logic [RADIUS_W-1:0] radius_q = RADIUS_RST;
	logic [CNT_W-1:0] slices_q = SLICE_RST;
	logic [CNT_W-1:0] stacks_q = STACK_RST;

	vertex_t pending_vertices[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quads_sent = 0;
	int vertices_seen = 0;
	int cfg_writes = 0;
	int errors = 0;

	sphere_quad_vertex_generator i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.stack_index(stack_index), .slice_index(slice_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.tex_u(tex_u), .tex_v(tex_v), .last_corner(last_corner)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	// atan(2^-i) in turns, 2^32 to the turn; only the stages the block runs.
	localparam logic [31:0] ATAN_TURNS [16] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};
	localparam int BEAT_CORNER [6] = '{0, 1, 2, 2, 1, 3};

	function automatic longint sat_unit(input longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	// Rotation-mode CORDIC on a 32-bit phase, folded into +-90 degrees first.
	function automatic void phase_sin_cos(input logic [31:0] ph, output longint sn, cs);
		longint z, x, y, nx;
		bit flip;
		z = ph[31] ? longint'(ph) - 64'sh100000000 : longint'(ph);
		flip = 1'b0;
		x = longint'(CORDIC_GAIN);
		y = 0;
		if (z > 64'sh40000000) begin
			z -= 64'sh80000000;
			flip = 1'b1;
		end else if (z < -64'sh40000000) begin
			z += 64'sh80000000;
			flip = 1'b1;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TURNS[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TURNS[i]);
			end
			x = nx;
		end
		cs = sat_unit((x + 32768) >>> 16);
		sn = sat_unit((y + 32768) >>> 16);
		if (flip) begin
			cs = -cs;
			sn = -sn;
		end
	endfunction

	function automatic longint div_count(input logic [CNT_W-1:0] c);
		if (c == 0) return 1;
		if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
		return c;
	endfunction

	function automatic longint tex_frac(input longint k, n);
		longint v;
		v = (k * 131072 + n) / (2 * n);
		return (v > 65536) ? 65536 : v;
	endfunction

	// Queue the six vertices a quad should produce under the current registers.
	function automatic void predict_quad_vertices(input logic [IDX_W-1:0] stk, slc);
		longint ns, nl, ks, kl, nxv, nyv, nzv, rad;
		longint srho[2], crho[2], sth[2], cth[2];
		logic [31:0] prho, pth;
		vertex_t corners[4];
		vertex_t vtx;
		int r, t;
		ns = div_count(stacks_q);
		nl = div_count(slices_q);
		rad = longint'(radius_q);
		for (int k = 0; k < 2; k++) begin
			ks = longint'(stk) + k;
			kl = longint'(slc) + k;
			prho = 32'(((ks << 32) + ns) / (2 * ns));
			// slice wrap: the next slice after the last one is back at angle zero
			pth = (k == 1 && kl == nl) ? 32'd0 : 32'(((kl << 33) + nl) / (2 * nl));
			phase_sin_cos(prho, srho[k], crho[k]);
			phase_sin_cos(pth, sth[k], cth[k]);
		end
		for (int c = 0; c < 4; c++) begin
			r = c & 1;
			t = c >> 1;
			nxv = sat_unit((-sth[t] * srho[r] + 8192) >>> 14);
			nyv = sat_unit((cth[t] * srho[r] + 8192) >>> 14);
			nzv = crho[r];
			corners[c].px = POS_W'((nxv * rad + 8192) >>> 14);
			corners[c].py = POS_W'((nyv * rad + 8192) >>> 14);
			corners[c].pz = POS_W'((nzv * rad + 8192) >>> 14);
			corners[c].nx = Q14_W'(nxv);
			corners[c].ny = Q14_W'(nyv);
			corners[c].nz = Q14_W'(nzv);
			corners[c].u = TEX_W'(tex_frac(longint'(slc) + t, nl));
			corners[c].v = TEX_W'(65536 - tex_frac(longint'(stk) + r, ns));
			corners[c].last = 1'b0;
		end
		for (int b = 0; b < 6; b++) begin
			vtx = corners[BEAT_CORNER[b]];
			vtx.last = (b == 5);
			pending_vertices = {pending_vertices, vtx};
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	// Send one quad; idle beforehand at the current rate, hold until accepted.
	task automatic send_quad(input logic [IDX_W-1:0] stk, slc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		stack_index = stk;
		slice_index = slc;
		do @(posedge clk); while (in_stall);
		predict_quad_vertices(stk, slc);
		quads_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RADIUS:      radius_q = val;
			REG_SLICE_COUNT: slices_q = val[CNT_W-1:0];
			REG_STACK_COUNT: stacks_q = val[CNT_W-1:0];
			default:         ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold off until every predicted vertex has come back.
	task automatic wait_drained();
		while (pending_vertices.size() != 0) @(negedge clk);
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		out_stall = arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, last_corner};
			vertices_seen++;
			if (pending_vertices.size() == 0) begin
				$display("%0t: unexpected vertex beat %p", $time, got);
				errors++;
			end else begin
				want = pending_vertices.pop_front();
				if (got.px !== want.px) begin
					$display("%0t: pos_x expected %0d got %0d", $time, want.px, got.px);
					errors++;
				end
				if (got.py !== want.py) begin
					$display("%0t: pos_y expected %0d got %0d", $time, want.py, got.py);
					errors++;
				end
				if (got.pz !== want.pz) begin
					$display("%0t: pos_z expected %0d got %0d", $time, want.pz, got.pz);
					errors++;
				end
				if (got.nx !== want.nx) begin
					$display("%0t: norm_x expected %0d got %0d", $time, want.nx, got.nx);
					errors++;
				end
				if (got.ny !== want.ny) begin
					$display("%0t: norm_y expected %0d got %0d", $time, want.ny, got.ny);
					errors++;
				end
				if (got.nz !== want.nz) begin
					$display("%0t: norm_z expected %0d got %0d", $time, want.nz, got.nz);
					errors++;
				end
				if (got.u !== want.u) begin
					$display("%0t: tex_u expected %0d got %0d", $time, want.u, got.u);
					errors++;
				end
				if (got.v !== want.v) begin
					$display("%0t: tex_v expected %0d got %0d", $time, want.v, got.v);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last_corner expected %0b got %0b", $time, want.last, got.last);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		return '{ROW_CFG, idx, val, '0, '0, 1'b0, '0, '0};
	endfunction

	function automatic row_t quad_row(input logic [IDX_W-1:0] stk, slc, input bit known,
			input logic [TEX_W-1:0] u0, v0);
		return '{ROW_QUAD, REG_RADIUS, '0, stk, slc, known, u0, v0};
	endfunction

	// Random quad: mostly inside the configured grid, sometimes anywhere.
	task automatic send_random_quad();
		longint ns, nl;
		ns = div_count(stacks_q);
		nl = div_count(slices_q);
		if ($urandom_range(99) < 15 || ns > 256 || nl > 256) begin
			send_quad(IDX_W'($urandom), IDX_W'($urandom));
		end else begin
			send_quad(IDX_W'($urandom_range(ns - 1)), IDX_W'($urandom_range(nl - 1)));
		end
	endtask

	// Random register setting: small grids mostly, full 16-bit data now and then.
	task automatic randomize_regs();
		write_reg(REG_RADIUS, CFG_DATA_W'($urandom));
		case ($urandom_range(3))
			0:       write_reg(REG_SLICE_COUNT, CFG_DATA_W'($urandom));
			default: write_reg(REG_SLICE_COUNT, CFG_DATA_W'($urandom_range(32, 3)));
		endcase
		case ($urandom_range(3))
			0:       write_reg(REG_STACK_COUNT, CFG_DATA_W'($urandom));
			default: write_reg(REG_STACK_COUNT, CFG_DATA_W'($urandom_range(32, 2)));
		endcase
	endtask

	initial begin
		row_t plan[$];
		int idle_modes[4][2];
		int vbase;
		idle_modes = '{'{0, 0}, '{61, 0}, '{0, 61}, '{31, 31}};

		// Reset-value quads with texture coordinates read straight off the grid,
		// then the register extremes, zero and oversize counts, and an unmapped write.
		plan = '{
			quad_row(0, 0, 1, 0, 65536),
			quad_row(15, 15, 1, 61440, 4096),
			quad_row(255, 255, 1, 65536, 0),
			quad_row(0, 255, 1, 65536, 65536),
			quad_row(255, 0, 1, 0, 0),
			quad_row(8, 4, 0, 0, 0),
			cfg_row(REG_RADIUS, 16'hFFFF),
			cfg_row(REG_SLICE_COUNT, 16'd3),
			cfg_row(REG_STACK_COUNT, 16'd2),
			quad_row(0, 0, 0, 0, 0),
			quad_row(1, 2, 0, 0, 0),
			quad_row(2, 3, 0, 0, 0),
			cfg_row(REG_RADIUS, 16'd0),
			cfg_row(REG_SLICE_COUNT, 16'd256),
			cfg_row(REG_STACK_COUNT, 16'd256),
			quad_row(255, 255, 1, 65280, 256),
			quad_row(128, 64, 0, 0, 0),
			cfg_row(REG_RADIUS, 16'd256),
			cfg_row(REG_SLICE_COUNT, 16'd0),
			cfg_row(REG_STACK_COUNT, 16'h01FF),
			cfg_row(REG_UNMAPPED, 16'hFFFF),
			quad_row(0, 0, 1, 0, 65536),
			quad_row(200, 1, 0, 0, 0)
		};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pass: drain before every register write so the block is idle.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_quad(plan[i].stk, plan[i].slc);
				// the new quad's six vertices sit at the tail of the queue
				vbase = pending_vertices.size() - 6;
				if (plan[i].tex_known) begin
					// pin the first vertex to the hand-computed coordinates
					pending_vertices[vbase].u = plan[i].u0;
					pending_vertices[vbase].v = plan[i].v0;
				end
			end
		end

		// Random pass: four idling phases, fresh registers for each.
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			randomize_regs();
			send_idle_pct = idle_modes[p][0];
			recv_stall_pct = idle_modes[p][1];
			for (int n = 0; n < 54; n++) begin
				// stretch with no gaps inside every phase
				if (n == 20) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end else if (n == 30) begin
					send_idle_pct = idle_modes[p][0];
					recv_stall_pct = idle_modes[p][1];
				end
				// let the pipeline run completely empty once mid-run
				if (p == 1 && n == 29) wait_drained();
				send_random_quad();
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d quads, %0d vertex beats, %0d register writes", quads_sent,
			vertices_seen, cfg_writes);
		$display("over four back-pressure mixes, grid extremes and out-of-range indices.");
		if (errors == 0 && pending_vertices.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#20ms;
		$display("Timeout with %0d vertices outstanding", pending_vertices.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
